// File: rtl/senn_pkg.sv
// Package: constants, types and codes for the scaled Euclidean nearest neighbor block.
package senn_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int NUM_FEAT = 4;
    localparam int FEAT_W   = 24;
    localparam int INV_W    = 24;
    localparam int CLASS_W  = 8;
    localparam int CMD_W    = 2;
    localparam int DIST_W   = 49;
    localparam int FRAC_W   = 16;
    localparam int MAG_W    = FEAT_W + 1;
    localparam int PROD_W   = MAG_W + INV_W;
    localparam int SHR_W    = PROD_W - FRAC_W;
    localparam int SAT_W    = FEAT_W - 1;
    localparam int SQ_W     = 2 * SAT_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = DIST_W;

    localparam logic [SAT_W-1:0]  SAT_MAG      = {SAT_W{1'b1}};
    localparam logic [INV_W-1:0]  INV_RESET    = INV_W'(65536);
    localparam logic [DIST_W-1:0] REJECT_RESET = DIST_W'(64'd17179869184);
    localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_FILL     = 3'd0,
        CFG_INV_ASPECT   = 3'd1,
        CFG_INV_MOM_ONE  = 3'd2,
        CFG_INV_MOM_TWO  = 3'd3,
        CFG_REJECT       = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef logic [NUM_FEAT-1:0][FEAT_W-1:0] t_feat_vec;
    typedef logic [NUM_FEAT-1:0][INV_W-1:0]  t_inv_vec;

    typedef struct packed {
        t_feat_vec           feats;
        logic [CLASS_W-1:0]  cls;
    } t_row;

    typedef struct packed {
        logic                valid;
        logic [SUM_W-1:0]    sum;
        logic [CLASS_W-1:0]  cls;
    } t_dist_res;

endpackage

// File: rtl/scaled_euclidean_nearest_neighbor.sv
// Nearest neighbor classifier over a table of labelled four-feature vectors, scaled Euclidean.
// With the output free, clear, append and the unused command load their result in the cycle
// after acceptance. A classify, with the output free, loads its result once every stored entry
// has been read and the distance pipeline has drained. The next item is accepted in the cycle
// after the result is loaded. The classify time is set by the single read port of the table
// memory, which yields one entry per cycle. The registered read, the five-stage distance
// pipeline, the minimum update and a check that the pipeline has drained follow it. One item
// is in work at a time; the next item is accepted while the previous result still waits on
// the output.
module scaled_euclidean_nearest_neighbor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [senn_pkg::CMD_W-1:0]      i_command,
    input  logic signed [senn_pkg::FEAT_W-1:0] i_feat_fill,
    input  logic signed [senn_pkg::FEAT_W-1:0] i_feat_aspect,
    input  logic signed [senn_pkg::FEAT_W-1:0] i_feat_moment_one,
    input  logic signed [senn_pkg::FEAT_W-1:0] i_feat_moment_two,
    input  logic [senn_pkg::CLASS_W-1:0]    i_entry_class,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_status,
    output logic                            o_known,
    output logic [senn_pkg::CLASS_W-1:0]    o_best_class,
    output logic [senn_pkg::DIST_W-1:0]     o_best_dist_sq,
    input  logic                            i_cfg_wr_en,
    input  logic [senn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [senn_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    senn_pkg::t_state r_state, n_state;
    senn_pkg::t_cmd   r_cmd;
    senn_pkg::t_feat_vec r_query;
    senn_pkg::t_inv_vec  r_inv;
    logic [senn_pkg::DIST_W-1:0]  r_reject;
    logic [senn_pkg::CNT_W-1:0]   r_count;
    logic [senn_pkg::CNT_W-1:0]   r_rd_cnt;
    logic                         r_status;
    logic [senn_pkg::DIST_W-1:0]  r_best;
    logic [senn_pkg::CLASS_W-1:0] r_best_cls;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic                         r_out_known;
    logic [senn_pkg::CLASS_W-1:0] r_out_class;
    logic [senn_pkg::DIST_W-1:0]  r_out_dist;

    logic accept, rd_en, load_out, has_room, scan_more, busy, res_known;
    senn_pkg::t_row      wr_row, rd_row;
    senn_pkg::t_feat_vec in_feats;
    senn_pkg::t_dist_res dres;

    assign in_feats  = {i_feat_moment_two, i_feat_moment_one, i_feat_aspect, i_feat_fill};
    assign accept    = i_valid && o_ready;
    assign has_room  = r_count < senn_pkg::CNT_W'(senn_pkg::TABLE_DEPTH);
    assign scan_more = r_rd_cnt < r_count;
    assign wr_row.feats = in_feats;
    assign wr_row.cls   = i_entry_class;
    assign res_known = (r_count != '0) && (r_best <= r_reject);

    senn_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (senn_pkg::t_cmd'(i_command) == senn_pkg::CMD_APPEND) && has_room),
        .i_wr_addr (r_count[senn_pkg::ADDR_W-1:0]),
        .i_wr_row  (wr_row),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_cnt[senn_pkg::ADDR_W-1:0]),
        .o_rd_row  (rd_row)
    );

    senn_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (rd_en),
        .i_row   (rd_row),
        .i_query (r_query),
        .i_inv   (r_inv),
        .o_res   (dres),
        .o_busy  (busy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            senn_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (senn_pkg::t_cmd'(i_command) == senn_pkg::CMD_CLASSIFY)
                            ? senn_pkg::S_SCAN : senn_pkg::S_FIN;
                end
            end
            senn_pkg::S_SCAN: begin
                if (!scan_more) begin
                    n_state = senn_pkg::S_DRAIN;
                end
            end
            senn_pkg::S_DRAIN: begin
                if (!busy) begin
                    n_state = senn_pkg::S_FIN;
                end
            end
            senn_pkg::S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_state = senn_pkg::S_IDLE;
                end
            end
            default: n_state = senn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            senn_pkg::S_IDLE:  o_ready  = 1'b1;
            senn_pkg::S_SCAN:  rd_en    = scan_more;
            senn_pkg::S_DRAIN: ;
            senn_pkg::S_FIN:   load_out = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= senn_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_inv       <= {senn_pkg::NUM_FEAT{senn_pkg::INV_RESET}};
            r_reject    <= senn_pkg::REJECT_RESET;
        end else begin
            r_state <= n_state;
            if (accept) begin
                unique case (senn_pkg::t_cmd'(i_command))
                    senn_pkg::CMD_CLEAR:  r_count <= '0;
                    senn_pkg::CMD_APPEND: begin
                        if (has_room) begin
                            r_count <= r_count + senn_pkg::CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (senn_pkg::t_cfg_idx'(i_cfg_index))
                    senn_pkg::CFG_INV_FILL:    r_inv[0] <= i_cfg_data[senn_pkg::INV_W-1:0];
                    senn_pkg::CFG_INV_ASPECT:  r_inv[1] <= i_cfg_data[senn_pkg::INV_W-1:0];
                    senn_pkg::CFG_INV_MOM_ONE: r_inv[2] <= i_cfg_data[senn_pkg::INV_W-1:0];
                    senn_pkg::CFG_INV_MOM_TWO: r_inv[3] <= i_cfg_data[senn_pkg::INV_W-1:0];
                    senn_pkg::CFG_REJECT:      r_reject <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= senn_pkg::t_cmd'(i_command);
            r_query    <= in_feats;
            r_status   <= (senn_pkg::t_cmd'(i_command) == senn_pkg::CMD_APPEND) && !has_room;
            r_rd_cnt   <= '0;
            r_best     <= senn_pkg::DIST_ALL_ONES;
            r_best_cls <= '0;
        end else begin
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + senn_pkg::CNT_W'(1);
            end
            if (dres.valid && (senn_pkg::DIST_W'(dres.sum) < r_best)) begin
                r_best     <= senn_pkg::DIST_W'(dres.sum);
                r_best_cls <= dres.cls;
            end
        end
        if (load_out) begin
            r_out_status <= r_status;
            if (r_cmd == senn_pkg::CMD_CLASSIFY) begin
                r_out_known <= res_known;
                r_out_class <= res_known ? r_best_cls : '0;
                r_out_dist  <= r_best;
            end else begin
                r_out_known <= 1'b0;
                r_out_class <= '0;
                r_out_dist  <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_known        = r_out_known;
    assign o_best_class   = r_out_class;
    assign o_best_dist_sq = r_out_dist;

`ifndef SYNTH
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !busy)
        else $error("distance pipeline busy while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= senn_pkg::CNT_W'(senn_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_res_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dres.valid |-> (r_state == senn_pkg::S_SCAN || r_state == senn_pkg::S_DRAIN))
        else $error("distance result outside a classify");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_state == senn_pkg::S_FIN && !busy))
        else $error("result loaded before pipeline drained");
`endif

endmodule

// File: rtl/senn_store.sv
// Table memory: one row per entry (four features and class), registered read.
module senn_store (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [senn_pkg::ADDR_W-1:0] i_wr_addr,
    input  senn_pkg::t_row              i_wr_row,
    input  logic                        i_rd_en,
    input  logic [senn_pkg::ADDR_W-1:0] i_rd_addr,
    output senn_pkg::t_row              o_rd_row
);

    senn_pkg::t_row r_mem [senn_pkg::TABLE_DEPTH];
    senn_pkg::t_row r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// File: rtl/senn_dist.sv
// Distance pipeline: scaled difference, saturate, square and sum per table row.
module senn_dist (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  senn_pkg::t_row       i_row,
    input  senn_pkg::t_feat_vec  i_query,
    input  senn_pkg::t_inv_vec   i_inv,
    output senn_pkg::t_dist_res  o_res,
    output logic                 o_busy
);

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [senn_pkg::CLASS_W-1:0] r_cls1, r_cls2, r_cls3, r_cls4, r_cls5;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::MAG_W-1:0]  r_mag;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::PROD_W-1:0] r_prod;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::SAT_W-1:0]  r_sat;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::SQ_W-1:0]   r_sq;
    logic [senn_pkg::SUM_W-1:0] r_sum;

    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::MAG_W-1:0]  n_mag;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::SAT_W-1:0]  n_sat;
    logic [senn_pkg::NUM_FEAT-1:0][senn_pkg::SHR_W-1:0]  shr;
    logic signed [senn_pkg::NUM_FEAT-1:0][senn_pkg::MAG_W-1:0] diff;
    logic [senn_pkg::SUM_W-1:0] n_sum;

    always_comb begin
        for (int k = 0; k < senn_pkg::NUM_FEAT; k++) begin
            diff[k] = $signed({i_query[k][senn_pkg::FEAT_W-1], i_query[k]})
                    - $signed({i_row.feats[k][senn_pkg::FEAT_W-1], i_row.feats[k]});
            n_mag[k] = diff[k][senn_pkg::MAG_W-1] ? (~diff[k] + senn_pkg::MAG_W'(1))
                                                 : diff[k];
            shr[k] = r_prod[k][senn_pkg::PROD_W-1:senn_pkg::FRAC_W];
            n_sat[k] = (shr[k] > senn_pkg::SHR_W'(senn_pkg::SAT_MAG))
                     ? senn_pkg::SAT_MAG : shr[k][senn_pkg::SAT_W-1:0];
        end
        n_sum = '0;
        for (int k = 0; k < senn_pkg::NUM_FEAT; k++) begin
            n_sum = n_sum + senn_pkg::SUM_W'(r_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v0 <= i_rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls1 <= i_row.cls;
        r_cls2 <= r_cls1;
        r_cls3 <= r_cls2;
        r_cls4 <= r_cls3;
        r_cls5 <= r_cls4;
        r_mag  <= n_mag;
        for (int k = 0; k < senn_pkg::NUM_FEAT; k++) begin
            r_prod[k] <= senn_pkg::PROD_W'(r_mag[k]) * senn_pkg::PROD_W'(i_inv[k]);
            r_sq[k]   <= senn_pkg::SQ_W'(r_sat[k]) * senn_pkg::SQ_W'(r_sat[k]);
        end
        r_sat <= n_sat;
        r_sum <= n_sum;
    end

    assign o_res.valid = r_v5;
    assign o_res.sum   = r_sum;
    assign o_res.cls   = r_cls5;
    assign o_busy      = r_v0 | r_v1 | r_v2 | r_v3 | r_v4 | r_v5;

endmodule

// File: sim/tb.sv
// Testbench for scaled_euclidean_nearest_neighbor: directed table, random bursts, self-checking.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic                         status;
        logic                         known;
        logic [senn_pkg::CLASS_W-1:0] cls;
        logic [senn_pkg::DIST_W-1:0]  dist_sq;
    } t_verdict;

    typedef struct packed {
        senn_pkg::t_cmd               cmd;
        logic [senn_pkg::FEAT_W-1:0]  fill;
        logic [senn_pkg::FEAT_W-1:0]  aspect;
        logic [senn_pkg::FEAT_W-1:0]  mom_one;
        logic [senn_pkg::FEAT_W-1:0]  mom_two;
        logic [senn_pkg::CLASS_W-1:0] cls;
        logic                         pinned;
        t_verdict                     want;
    } t_dir_row;

    localparam t_verdict V_DONE  = '0;
    localparam t_verdict V_EMPTY = '{1'b0, 1'b0, 8'h00, senn_pkg::DIST_ALL_ONES};
    localparam int       N_DIRECTED = 20;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    senn_pkg::t_cmd                  i_command = senn_pkg::CMD_NOP;
    logic [senn_pkg::FEAT_W-1:0]     i_feat_fill = '0;
    logic [senn_pkg::FEAT_W-1:0]     i_feat_aspect = '0;
    logic [senn_pkg::FEAT_W-1:0]     i_feat_moment_one = '0;
    logic [senn_pkg::FEAT_W-1:0]     i_feat_moment_two = '0;
    logic [senn_pkg::CLASS_W-1:0]    i_entry_class = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_status;
    logic                            o_known;
    logic [senn_pkg::CLASS_W-1:0]    o_best_class;
    logic [senn_pkg::DIST_W-1:0]     o_best_dist_sq;
    logic                            i_cfg_wr_en = 1'b0;
    senn_pkg::t_cfg_idx              i_cfg_index = senn_pkg::CFG_INV_FILL;
    logic [senn_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor state
    senn_pkg::t_feat_vec          table_feats [senn_pkg::TABLE_DEPTH];
    logic [senn_pkg::CLASS_W-1:0] table_class [senn_pkg::TABLE_DEPTH];
    int                           table_fill = 0;
    senn_pkg::t_inv_vec           model_inv = {senn_pkg::NUM_FEAT{senn_pkg::INV_RESET}};
    logic [senn_pkg::DIST_W-1:0]  model_reject = senn_pkg::REJECT_RESET;

    t_verdict pending_verdicts [$];
    t_dir_row directed_rows [N_DIRECTED];
    int       items_sent = 0;
    int       verdicts_seen = 0;
    int       random_items = 0;
    int       failures = 0;
    bit       tx_calm = 1'b0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    scaled_euclidean_nearest_neighbor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_feat_fill      (i_feat_fill),
        .i_feat_aspect    (i_feat_aspect),
        .i_feat_moment_one(i_feat_moment_one),
        .i_feat_moment_two(i_feat_moment_two),
        .i_entry_class    (i_entry_class),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_known          (o_known),
        .o_best_class     (o_best_class),
        .o_best_dist_sq   (o_best_dist_sq),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned scaled_square(
        input logic [senn_pkg::FEAT_W-1:0] q, e,
        input logic [senn_pkg::INV_W-1:0] inv);
        longint          diff;
        longint unsigned mag, s;
        diff = longint'($signed(q)) - longint'($signed(e));
        mag = (diff < 0) ? -diff : diff;
        s = (mag * inv) >> senn_pkg::FRAC_W;
        if (s > senn_pkg::SAT_MAG) s = senn_pkg::SAT_MAG;
        return s * s;
    endfunction

    function automatic t_verdict predict_verdict(input senn_pkg::t_cmd cmd,
                                                 input senn_pkg::t_feat_vec fv,
                                                 input logic [senn_pkg::CLASS_W-1:0] cls);
        t_verdict        v;
        longint unsigned best, sum;
        int              best_at;
        v = '0;
        case (cmd)
            senn_pkg::CMD_CLEAR: table_fill = 0;
            senn_pkg::CMD_APPEND: begin
                if (table_fill < senn_pkg::TABLE_DEPTH) begin
                    table_feats[table_fill] = fv;
                    table_class[table_fill] = cls;
                    table_fill++;
                end else begin
                    v.status = 1'b1;
                end
            end
            senn_pkg::CMD_CLASSIFY: begin
                best = senn_pkg::DIST_ALL_ONES;
                best_at = -1;
                for (int n = 0; n < table_fill; n++) begin
                    sum = 0;
                    for (int k = 0; k < senn_pkg::NUM_FEAT; k++)
                        sum += scaled_square(fv[k], table_feats[n][k], model_inv[k]);
                    // first strict minimum wins
                    if (best_at < 0 || sum < best) begin
                        best = sum;
                        best_at = n;
                    end
                end
                v.dist_sq = best[senn_pkg::DIST_W-1:0];
                if (best_at >= 0 && best <= model_reject) begin
                    v.known = 1'b1;
                    v.cls = table_class[best_at];
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic logic [senn_pkg::FEAT_W-1:0] rand_feat();
        if ($urandom_range(1) != 0) return senn_pkg::FEAT_W'($urandom);
        return senn_pkg::FEAT_W'($urandom_range(20'hFFFFF) - 32'h80000);
    endfunction

    task automatic send_item(input senn_pkg::t_cmd cmd, input senn_pkg::t_feat_vec fv,
                             input logic [senn_pkg::CLASS_W-1:0] cls, input logic pinned,
                             input t_verdict want);
        t_verdict v;
        while (!tx_calm && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_feat_fill       <= fv[0];
        i_feat_aspect     <= fv[1];
        i_feat_moment_one <= fv[2];
        i_feat_moment_two <= fv[3];
        i_entry_class     <= cls;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        v = predict_verdict(cmd, fv, cls);
        if (pinned) v = want;
        pending_verdicts.insert(pending_verdicts.size(), v);
        items_sent++;
    endtask

    task automatic apply_setting(input senn_pkg::t_inv_vec inv,
                                 input logic [senn_pkg::DIST_W-1:0] reject);
        i_valid <= 1'b0;
        while (verdicts_seen != items_sent) @(posedge i_clk);
        for (int r = senn_pkg::CFG_INV_FILL; r <= senn_pkg::CFG_REJECT; r++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= senn_pkg::t_cfg_idx'(r);
            if (r == senn_pkg::CFG_REJECT) begin
                i_cfg_data <= reject;
                model_reject = reject;
            end else begin
                i_cfg_data <= senn_pkg::CFG_DATA_W'(inv[r]);
                model_inv[r] = inv[r];
            end
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // lone random command, or optional clear, appends, then queries mostly near stored entries
    task automatic run_burst(input bit force_full);
        senn_pkg::t_cmd      cmd;
        senn_pkg::t_feat_vec fv;
        int                  appends, queries, idx, span;
        if (!force_full && $urandom_range(99) < 10) begin
            cmd = senn_pkg::t_cmd'($urandom_range(senn_pkg::CMD_NOP));
            for (int k = 0; k < senn_pkg::NUM_FEAT; k++) fv[k] = senn_pkg::FEAT_W'($urandom);
            send_item(cmd, fv, senn_pkg::CLASS_W'($urandom), 1'b0, V_DONE);
            if (cmd != senn_pkg::CMD_NOP) random_items++;
            return;
        end
        if (force_full || $urandom_range(3) == 0) begin
            for (int k = 0; k < senn_pkg::NUM_FEAT; k++) fv[k] = senn_pkg::FEAT_W'($urandom);
            send_item(senn_pkg::CMD_CLEAR, fv, senn_pkg::CLASS_W'($urandom), 1'b0, V_DONE);
            random_items++;
        end
        if (force_full)
            appends = senn_pkg::TABLE_DEPTH + 2;
        else if ($urandom_range(9) == 0)
            appends = $urandom_range(senn_pkg::TABLE_DEPTH + 4, senn_pkg::TABLE_DEPTH - 4);
        else
            appends = $urandom_range(8, 1);
        repeat (appends) begin
            for (int k = 0; k < senn_pkg::NUM_FEAT; k++) fv[k] = rand_feat();
            send_item(senn_pkg::CMD_APPEND, fv, senn_pkg::CLASS_W'($urandom), 1'b0, V_DONE);
            random_items++;
        end
        queries = $urandom_range(4, 1);
        repeat (queries) begin
            if (table_fill != 0 && $urandom_range(3) != 0) begin
                idx = $urandom_range(table_fill - 1);
                case ($urandom_range(2))
                    0: span = 0;
                    1: span = 'hFF;
                    default: span = 'h1FFFF;
                endcase
                for (int k = 0; k < senn_pkg::NUM_FEAT; k++)
                    fv[k] = table_feats[idx][k]
                          + senn_pkg::FEAT_W'($urandom_range(2 * span) - span);
            end else begin
                for (int k = 0; k < senn_pkg::NUM_FEAT; k++) fv[k] = rand_feat();
            end
            send_item(senn_pkg::CMD_CLASSIFY, fv, senn_pkg::CLASS_W'($urandom), 1'b0, V_DONE);
            random_items++;
        end
    endtask

    // receiver: random stalls, one long hold-off, one calm stretch
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && verdicts_seen >= 150) begin
            i_ready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else begin
            i_ready <= (verdicts_seen >= 260 && verdicts_seen < 360) || $urandom_range(99) >= 19;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            verdicts_seen <= verdicts_seen + 1;
            if (pending_verdicts.size() == 0) begin
                $error("result with no item waiting for it");
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("status", want.status, o_status);
                check_field("known", want.known, o_known);
                check_field("best_class", want.cls, o_best_class);
                check_field("best_dist_sq", want.dist_sq, o_best_dist_sq);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        // cmd, fill, aspect, moment_one, moment_two, class, pinned, expected
        directed_rows = '{
            '{senn_pkg::CMD_CLASSIFY, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
              8'h00, 1'b1, V_EMPTY},
            '{senn_pkg::CMD_NOP,      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              8'hFF, 1'b1, V_DONE},
            '{senn_pkg::CMD_APPEND,   24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
              8'hFF, 1'b1, V_DONE},
            '{senn_pkg::CMD_APPEND,   24'h800000, 24'h800000, 24'h800000, 24'h800000,
              8'h00, 1'b1, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
              8'h5A, 1'b1, '{1'b0, 1'b1, 8'hFF, 49'd0}},
            '{senn_pkg::CMD_CLASSIFY, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
              8'hA5, 1'b1, '{1'b0, 1'b1, 8'h00, 49'd0}},
            // equal saturated sums, first entry stays
            '{senn_pkg::CMD_CLASSIFY, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
              8'h00, 1'b0, V_DONE},
            '{senn_pkg::CMD_APPEND,   24'h010000, 24'h020000, 24'hFF0000, 24'h008000,
              8'h07, 1'b1, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h020000, 24'h020000, 24'hFF0000, 24'h008000,
              8'h00, 1'b0, V_DONE},
            // exactly on the threshold, then one lsb past it
            '{senn_pkg::CMD_CLASSIFY, 24'h030000, 24'h020000, 24'hFF0000, 24'h008000,
              8'h00, 1'b0, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h030001, 24'h020000, 24'hFF0000, 24'h008000,
              8'h00, 1'b0, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h010000, 24'h020000, 24'hFF0000, 24'h008000,
              8'h00, 1'b1, '{1'b0, 1'b1, 8'h07, 49'd0}},
            '{senn_pkg::CMD_CLEAR,    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              8'hFF, 1'b1, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h010000, 24'h020000, 24'hFF0000, 24'h008000,
              8'h00, 1'b1, V_EMPTY},
            '{senn_pkg::CMD_APPEND,   24'h123456, 24'h0ABCDE, 24'hF00001, 24'h800001,
              8'h01, 1'b1, V_DONE},
            '{senn_pkg::CMD_APPEND,   24'h123456, 24'h0ABCDE, 24'hF00001, 24'h800001,
              8'h02, 1'b1, V_DONE},
            '{senn_pkg::CMD_CLASSIFY, 24'h123456, 24'h0ABCDE, 24'hF00001, 24'h800001,
              8'h00, 1'b1, '{1'b0, 1'b1, 8'h01, 49'd0}},
            '{senn_pkg::CMD_CLASSIFY, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF,
              8'h00, 1'b0, V_DONE},
            '{senn_pkg::CMD_NOP,      24'h000000, 24'h000000, 24'h000000, 24'h000000,
              8'h00, 1'b1, V_DONE},
            '{senn_pkg::CMD_APPEND,   24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800000,
              8'hC3, 1'b1, V_DONE}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            tx_calm = (ph == 1);
            case (ph)
                0: begin
                    foreach (directed_rows[r])
                        send_item(directed_rows[r].cmd,
                                  {directed_rows[r].mom_two, directed_rows[r].mom_one,
                                   directed_rows[r].aspect, directed_rows[r].fill},
                                  directed_rows[r].cls, directed_rows[r].pinned,
                                  directed_rows[r].want);
                    run_burst(1'b1);
                end
                1: apply_setting({senn_pkg::NUM_FEAT{24'hFFFFFF}}, senn_pkg::DIST_ALL_ONES);
                2: apply_setting('0, '0);
                3: apply_setting({senn_pkg::INV_W'($urandom), senn_pkg::INV_W'($urandom),
                                  senn_pkg::INV_W'($urandom), senn_pkg::INV_W'($urandom)},
                                 senn_pkg::DIST_W'({$urandom, $urandom})
                                     >> $urandom_range(48));
                default: apply_setting({24'h000001, 24'h100000, 24'h004000, 24'h010000},
                                       senn_pkg::DIST_W'(64'd68719476736));
            endcase
            while (random_items < (ph + 1) * 100) run_burst(1'b0);
        end

        i_valid <= 1'b0;
        while (verdicts_seen != items_sent) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", pending_verdicts.size());
            failures++;
        end
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
